/* design/tct_pkg.sv */
package tct_pkg;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_R     = 8'h72;

   // Result item kinds
   localparam logic [1:0] KIND_HEAD = 2'd0;
   localparam logic [1:0] KIND_CHAR = 2'd1;
   localparam logic [1:0] KIND_INT  = 2'd2;
   localparam logic [1:0] KIND_FIX  = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_NAME_LONG = 2'd1;
   localparam logic [1:0] ERR_TOO_MANY  = 2'd2;
   localparam logic [1:0] ERR_PARM_LONG = 2'd3;

   // Number bases
   localparam logic [4:0] BASE_BIN = 5'd2;
   localparam logic [4:0] BASE_OCT = 5'd8;
   localparam logic [4:0] BASE_DEC = 5'd10;
   localparam logic [4:0] BASE_HEX = 5'd16;

   localparam logic [5:0] DIGIT_NONE = 6'd63;

   // Reciprocal of ten for 20-bit dividends: q = (x * RECIP10) >> RECIP10_SH
   localparam logic [19:0] RECIP10    = 20'hCCCCD;
   localparam int          RECIP10_SH = 23;

   localparam int NAME_BYTES = 15;

   typedef enum logic [1:0] {MODE_WAIT, MODE_NAME, MODE_PARAM} mode_type;
   typedef enum logic [1:0] {S_IDLE, S_DECODE, S_EMIT} top_state_type;
   typedef enum logic [3:0] {
      D_IDLE, D_FIRST, D_BASE, D_WS, D_HX0, D_HX1, D_HX2,
      D_DIG, D_FSCAN, D_FDIV, D_FQ, D_SAT
   } dec_state_type;

   typedef struct packed {
      logic start;
      logic has_dot;
   } dec_cmd_type;

   typedef struct packed {
      logic        done;
      logic [1:0]  kind;
      logic [31:0] value;
   } dec_res_type;

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
             (c == CH_UNDER) || (c == CH_COMMA);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
   endfunction

   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [7:0] r;
      r = 8'(DIGIT_NONE);
      if (c inside {[8'h30:8'h39]}) r = c - 8'h30;
      else if (c inside {[8'h61:8'h7A]}) r = c - 8'h61 + 8'd10;
      else if (c inside {[8'h41:8'h5A]}) r = c - 8'h41 + 8'd10;
      return r[5:0];
   endfunction

   // Name bytes of the error command
   function automatic logic [7:0] err_byte(input int i);
      logic [7:0] r;
      r = CH_NUL;
      if (i == 0) r = CH_E;
      else if (i == 1 || i == 2) r = CH_R;
      return r;
   endfunction

endpackage

/* design/tct_ifs.sv */
interface tct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface tct_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         item_kind;
   logic [63:0]        name_low;
   logic [55:0]        name_high;
   logic signed [31:0] param_value;
   logic [3:0]         param_total;
   logic [1:0]         error_code;
   logic               last_item;

   modport source (output valid, output item_kind, output name_low, output name_high,
                   output param_value, output param_total, output error_code,
                   output last_item, input ready);
   modport sink   (input valid, input item_kind, input name_low, input name_high,
                   input param_value, input param_total, input error_code,
                   input last_item, output ready);
endinterface

/* design/tct_decode.sv */
// Parameter decoder: walks the stored token one byte per cycle through a
// shared multiply-accumulate unit, then a divide-by-ten step for fractions.
module tct_decode #(
   parameter int TOKEN_CHARS = 15
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tct_pkg::dec_cmd_type                   cmd,
   input  logic [$clog2(TOKEN_CHARS+1)-1:0]       tok_length,
   output logic [$clog2(TOKEN_CHARS+3)-1:0]       rd_index,
   input  logic [7:0]                             rd_data,
   output tct_pkg::dec_res_type                   res
);
   import tct_pkg::*;

   localparam int IW = $clog2(TOKEN_CHARS + 3);

   dec_state_type state_ff, state_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] fstart_ff, fstart_in;
   logic [32:0]   acc_ff, acc_in;
   logic [15:0]   q_ff, q_in;
   logic [39:0]   prod_ff, prod_in;
   logic          neg_ff, neg_in;
   logic          fix_ff, fix_in;
   logic [4:0]    base_ff, base_in;
   logic          done_ff, done_in;
   logic [1:0]    kind_ff, kind_in;
   logic [31:0]   value_ff, value_in;

   logic [5:0]    dig;
   logic          in_tok;
   logic [37:0]   mac_shift;
   logic [37:0]   mac_sum;
   logic [37:0]   mac_lim;
   logic [19:0]   frac_x;
   logic [32:0]   mag;

   // Shared arithmetic: acc * base + digit with clamp, and x / 10
   always_comb begin
      dig = digit_of(rd_data);
      in_tok = ptr_ff < IW'(tok_length);
      case (base_ff)
         BASE_BIN: mac_shift = {5'b0, acc_ff} << 1;
         BASE_OCT: mac_shift = {5'b0, acc_ff} << 3;
         BASE_HEX: mac_shift = {5'b0, acc_ff} << 4;
         default:  mac_shift = ({5'b0, acc_ff} << 3) + ({5'b0, acc_ff} << 1);
      endcase
      mac_sum = mac_shift + 38'(dig);
      mac_lim = fix_ff ? 38'h10000 : 38'h1_0000_0000;
      frac_x = {dig[3:0], 16'h0} + 20'(q_ff);
      prod_in = 40'(frac_x) * 40'(RECIP10);
      mag = fix_ff ? ({acc_ff[16:0], 16'h0} + 33'(q_ff)) : acc_ff;
   end

   // Read address
   always_comb begin
      case (state_ff)
         D_FIRST: rd_index = '0;
         D_BASE:  rd_index = IW'(1);
         D_HX1:   rd_index = ptr_ff + IW'(1);
         D_HX2:   rd_index = ptr_ff + IW'(2);
         default: rd_index = ptr_ff;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      fstart_in = fstart_ff;
      acc_in = acc_ff;
      q_in = q_ff;
      neg_in = neg_ff;
      fix_in = fix_ff;
      base_in = base_ff;
      done_in = 1'b0;
      kind_in = kind_ff;
      value_in = value_ff;
      case (state_ff)
         D_IDLE: begin
            if (cmd.start) begin
               fix_in = cmd.has_dot;
               state_in = D_FIRST;
            end
         end
         D_FIRST: begin
            acc_in = '0;
            q_in = '0;
            neg_in = 1'b0;
            if (tok_length == ($clog2(TOKEN_CHARS+1))'(1) && is_letter(rd_data)) begin
               done_in = 1'b1;
               kind_in = KIND_CHAR;
               value_in = 32'(rd_data);
               state_in = D_IDLE;
            end else if (rd_data == CH_HASH) begin
               state_in = D_BASE;
            end else begin
               base_in = BASE_DEC;
               ptr_in = '0;
               state_in = D_WS;
            end
         end
         D_BASE: begin
            fix_in = 1'b0;
            if (rd_data == 8'h4F || rd_data == 8'h6F) base_in = BASE_OCT;
            else if (rd_data == 8'h42 || rd_data == 8'h62) base_in = BASE_BIN;
            else base_in = BASE_HEX;
            ptr_in = IW'(2);
            state_in = D_WS;
         end
         D_WS: begin
            if (in_tok && is_space(rd_data)) begin
               ptr_in = ptr_ff + IW'(1);
            end else begin
               if (rd_data == CH_PLUS || rd_data == CH_MINUS) begin
                  neg_in = rd_data == CH_MINUS;
                  ptr_in = ptr_ff + IW'(1);
               end
               state_in = (base_ff == BASE_HEX && !fix_ff) ? D_HX0 : D_DIG;
            end
         end
         D_HX0: state_in = (rd_data == CH_ZERO) ? D_HX1 : D_DIG;
         D_HX1: state_in = (rd_data == 8'h78 || rd_data == 8'h58) ? D_HX2 : D_DIG;
         D_HX2: begin
            if (dig < 6'd16) ptr_in = ptr_ff + IW'(2);
            state_in = D_DIG;
         end
         D_DIG: begin
            if (in_tok && dig < 6'(base_ff)) begin
               acc_in = (mac_sum > mac_lim) ? mac_lim[32:0] : mac_sum[32:0];
               ptr_in = ptr_ff + IW'(1);
            end else if (fix_ff && rd_data == CH_DOT) begin
               ptr_in = ptr_ff + IW'(1);
               fstart_in = ptr_ff + IW'(1);
               state_in = D_FSCAN;
            end else begin
               state_in = D_SAT;
            end
         end
         // Find the end of the fraction, then fold its digits back to front
         D_FSCAN: begin
            if (in_tok && dig < 6'(BASE_DEC)) begin
               ptr_in = ptr_ff + IW'(1);
            end else if (ptr_ff == fstart_ff) begin
               state_in = D_SAT;
            end else begin
               ptr_in = ptr_ff - IW'(1);
               state_in = D_FDIV;
            end
         end
         D_FDIV: state_in = D_FQ;
         D_FQ: begin
            q_in = prod_ff[RECIP10_SH+15:RECIP10_SH];
            if (ptr_ff == fstart_ff) begin
               state_in = D_SAT;
            end else begin
               ptr_in = ptr_ff - IW'(1);
               state_in = D_FDIV;
            end
         end
         D_SAT: begin
            done_in = 1'b1;
            kind_in = fix_ff ? KIND_FIX : KIND_INT;
            if (neg_ff) value_in = (mag >= 33'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
            else value_in = (mag >= 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      ptr_ff <= ptr_in;
      fstart_ff <= fstart_in;
      acc_ff <= acc_in;
      q_ff <= q_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      fix_ff <= fix_in;
      base_ff <= base_in;
      kind_ff <= kind_in;
      value_ff <= value_in;
   end

   assign res.done = done_ff;
   assign res.kind = kind_ff;
   assign res.value = value_ff;

endmodule

/* design/text_command_tokenizer_unit.sv */
// Text command tokenizer. Takes one ASCII byte per transfer on req_chan and
// returns, for each completed command, a header item and then one item per
// parameter on rsp_chan, one item per cycle while the sink is ready. A
// delimiter or ';' that ends a parameter runs the decoder, which reads the
// stored token one byte per cycle through one shared multiply-accumulate
// unit, with extra steps for a '#' base and a divide-by-ten step per
// fraction digit for Q16.16 values. The output register lets the next byte
// in while the last item of a command waits to be taken.
module text_command_tokenizer_unit #(
   parameter int TOKEN_CHARS = 15,
   parameter int MAX_PARAMS  = 8
) (
   input logic        clock,
   input logic        reset,
   tct_req_if.sink    req_chan,
   tct_rsp_if.source  rsp_chan
);
   import tct_pkg::*;

   localparam int LEN_W = $clog2(TOKEN_CHARS + 1);
   localparam int TIW   = $clog2(TOKEN_CHARS);
   localparam int IW    = $clog2(TOKEN_CHARS + 3);
   localparam int PCW   = $clog2(MAX_PARAMS + 1);
   localparam int PIW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   top_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [7:0]    tok_ff [TOKEN_CHARS];
   logic [7:0]    tok_in [TOKEN_CHARS];
   logic [7:0]    cmd_ff [TOKEN_CHARS];
   logic [7:0]    cmd_in [TOKEN_CHARS];
   logic [1:0]    kinds_ff [MAX_PARAMS];
   logic [1:0]    kinds_in [MAX_PARAMS];
   logic [31:0]   values_ff [MAX_PARAMS];
   logic [31:0]   values_in [MAX_PARAMS];
   logic [LEN_W-1:0] tl_ff, tl_in;
   logic          dot_ff, dot_in;
   logic [7:0]    prev_ff, prev_in;
   logic [PCW-1:0] pc_ff, pc_in;
   logic [7:0]    pend_ff, pend_in;
   logic [PCW-1:0] em_count_ff, em_count_in;
   logic [PCW-1:0] em_idx_ff, em_idx_in;
   logic [1:0]    em_code_ff, em_code_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic [63:0]   rsp_low_ff, rsp_low_in;
   logic [55:0]   rsp_high_ff, rsp_high_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [3:0]    rsp_total_ff, rsp_total_in;
   logic [1:0]    rsp_code_ff, rsp_code_in;
   logic          rsp_last_ff, rsp_last_in;

   dec_cmd_type   dec_cmd;
   dec_res_type   dec_res;
   logic [IW-1:0] rd_index;
   logic [7:0]    rd_data;
   logic [7:0]    c;
   logic          accept;
   logic          load;
   logic [PCW-1:0] pc_next;
   logic [PIW-1:0] slot;
   logic [PIW-1:0] em_slot;
   logic [8*NAME_BYTES-1:0] name_bytes;

   // Name bytes beyond the configured length read as zero
   for (genvar g = 0; g < NAME_BYTES; g++) begin : g_name
      if (g < TOKEN_CHARS) begin : g_used
         assign name_bytes[8*g +: 8] = cmd_ff[g];
      end else begin : g_pad
         assign name_bytes[8*g +: 8] = CH_NUL;
      end
   end

   // Token read port for the decoder
   assign rd_data = (rd_index < IW'(tl_ff)) ? tok_ff[rd_index[TIW-1:0]] : CH_NUL;

   tct_decode #(.TOKEN_CHARS(TOKEN_CHARS)) u_decode (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dec_cmd),
      .tok_length (tl_ff),
      .rd_index   (rd_index),
      .rd_data    (rd_data),
      .res        (dec_res)
   );

   assign req_chan.ready = state_ff == S_IDLE;
   assign accept = req_chan.valid && req_chan.ready;
   assign c = req_chan.char_in;
   assign load = !rsp_valid_ff || rsp_chan.ready;
   assign slot = (pc_ff < PCW'(MAX_PARAMS)) ? pc_ff[PIW-1:0] : PIW'(MAX_PARAMS - 1);
   assign pc_next = (pc_ff < PCW'(MAX_PARAMS)) ? pc_ff + PCW'(1) : pc_ff;
   assign em_slot = PIW'(em_idx_ff - PCW'(1));

   // Byte parser, decode hand-off and emission sequencer
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      tok_in = tok_ff;
      cmd_in = cmd_ff;
      kinds_in = kinds_ff;
      values_in = values_ff;
      tl_in = tl_ff;
      dot_in = dot_ff;
      prev_in = prev_ff;
      pc_in = pc_ff;
      pend_in = pend_ff;
      em_count_in = em_count_ff;
      em_idx_in = em_idx_ff;
      em_code_in = em_code_ff;
      dec_cmd.start = 1'b0;
      dec_cmd.has_dot = dot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_low_in = rsp_low_ff;
      rsp_high_in = rsp_high_ff;
      rsp_value_in = rsp_value_ff;
      rsp_total_in = rsp_total_ff;
      rsp_code_in = rsp_code_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (c == CH_NUL || c == CH_BANG) begin
                  tl_in = '0;
                  dot_in = 1'b0;
                  pc_in = '0;
                  prev_in = CH_SPACE;
                  if (c == CH_BANG) mode_in = MODE_WAIT;
               end else if (c == CH_COLON) begin
                  mode_in = MODE_NAME;
                  tl_in = '0;
                  dot_in = 1'b0;
               end else begin
                  case (mode_ff)
                     MODE_NAME: begin
                        if (tl_ff >= LEN_W'(TOKEN_CHARS)) begin
                           for (int i = 0; i < TOKEN_CHARS; i++) cmd_in[i] = err_byte(i);
                           em_code_in = ERR_NAME_LONG;
                           em_count_in = '0;
                           em_idx_in = '0;
                           mode_in = MODE_WAIT;
                           state_in = S_EMIT;
                        end else if (c == CH_SEMI || is_delim(c)) begin
                           for (int i = 0; i < TOKEN_CHARS; i++) begin
                              if (LEN_W'(i) >= tl_ff) cmd_in[i] = CH_NUL;
                           end
                           pc_in = '0;
                           if (c == CH_SEMI) begin
                              em_code_in = ERR_NONE;
                              em_count_in = '0;
                              em_idx_in = '0;
                              mode_in = MODE_WAIT;
                              state_in = S_EMIT;
                           end else begin
                              mode_in = MODE_PARAM;
                              tl_in = '0;
                              dot_in = 1'b0;
                              prev_in = c;
                           end
                        end else begin
                           cmd_in[tl_ff[TIW-1:0]] = c;
                           tl_in = tl_ff + LEN_W'(1);
                        end
                     end
                     MODE_PARAM: begin
                        if (is_delim(c) || c == CH_SEMI) begin
                           if (!is_delim(prev_ff)) begin
                              pend_in = c;
                              dec_cmd.start = 1'b1;
                              state_in = S_DECODE;
                           end
                        end else if (tl_ff >= LEN_W'(TOKEN_CHARS)) begin
                           for (int i = 0; i < TOKEN_CHARS; i++) cmd_in[i] = err_byte(i);
                           em_code_in = ERR_PARM_LONG;
                           em_count_in = pc_ff;
                           em_idx_in = '0;
                           mode_in = MODE_WAIT;
                           state_in = S_EMIT;
                        end else begin
                           tok_in[tl_ff[TIW-1:0]] = c;
                           tl_in = tl_ff + LEN_W'(1);
                           prev_in = c;
                           if (c == CH_DOT) dot_in = 1'b1;
                        end
                     end
                     default: begin
                        mode_in = MODE_WAIT;
                        tl_in = '0;
                        dot_in = 1'b0;
                        pc_in = '0;
                     end
                  endcase
               end
            end
         end
         // Store the decoded parameter and finish the pending byte
         S_DECODE: begin
            if (dec_res.done) begin
               kinds_in[slot] = dec_res.kind;
               values_in[slot] = dec_res.value;
               tl_in = '0;
               dot_in = 1'b0;
               pc_in = pc_next;
               em_count_in = pc_next;
               em_idx_in = '0;
               if (pend_ff == CH_SEMI) begin
                  em_code_in = ERR_NONE;
                  mode_in = MODE_WAIT;
                  state_in = S_EMIT;
               end else if (pc_next >= PCW'(MAX_PARAMS)) begin
                  for (int i = 0; i < TOKEN_CHARS; i++) cmd_in[i] = err_byte(i);
                  em_code_in = ERR_TOO_MANY;
                  mode_in = MODE_WAIT;
                  state_in = S_EMIT;
               end else begin
                  prev_in = pend_ff;
                  state_in = S_IDLE;
               end
            end
         end
         // One result item per cycle into the output register while it is free or being taken
         S_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in = em_idx_ff == em_count_ff;
               if (em_idx_ff == '0) begin
                  rsp_kind_in = KIND_HEAD;
                  rsp_low_in = name_bytes[63:0];
                  rsp_high_in = name_bytes[8*NAME_BYTES-1:64];
                  rsp_value_in = '0;
                  rsp_total_in = 4'(em_count_ff);
                  rsp_code_in = em_code_ff;
               end else begin
                  rsp_kind_in = kinds_ff[em_slot];
                  rsp_low_in = '0;
                  rsp_high_in = '0;
                  rsp_value_in = values_ff[em_slot];
                  rsp_total_in = '0;
                  rsp_code_in = ERR_NONE;
               end
               if (em_idx_ff == em_count_ff) state_in = S_IDLE;
               else em_idx_in = em_idx_ff + PCW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= MODE_WAIT;
         tl_ff <= '0;
         dot_ff <= 1'b0;
         prev_ff <= CH_SPACE;
         pc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         tl_ff <= tl_in;
         dot_ff <= dot_in;
         prev_ff <= prev_in;
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_ff <= tok_in;
      cmd_ff <= cmd_in;
      kinds_ff <= kinds_in;
      values_ff <= values_in;
      pend_ff <= pend_in;
      em_count_ff <= em_count_in;
      em_idx_ff <= em_idx_in;
      em_code_ff <= em_code_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_low_ff <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_value_ff <= rsp_value_in;
      rsp_total_ff <= rsp_total_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.item_kind = rsp_kind_ff;
   assign rsp_chan.name_low = rsp_low_ff;
   assign rsp_chan.name_high = rsp_high_ff;
   assign rsp_chan.param_value = rsp_value_ff;
   assign rsp_chan.param_total = rsp_total_ff;
   assign rsp_chan.error_code = rsp_code_ff;
   assign rsp_chan.last_item = rsp_last_ff;

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PCW'(MAX_PARAMS)) else $error("parameter count out of range");

   a_tl_range: assert property (@(posedge clock) disable iff (reset)
      tl_ff <= LEN_W'(TOKEN_CHARS)) else $error("token length out of range");

   a_done_in_decode: assert property (@(posedge clock) disable iff (reset)
      dec_res.done |-> state_ff == S_DECODE) else $error("decode result while not waiting");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> em_idx_ff <= em_count_ff) else $error("emit index past count");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import tct_pkg::*;

   // One result item as seen on the response channel
   typedef struct {
      logic [1:0]  kind;
      logic [63:0] name_lo;
      logic [55:0] name_hi;
      logic [31:0] value;
      logic [3:0]  total;
      logic [1:0]  code;
      logic        last;
   } cmd_item_type;

   localparam int TOK_MAX   = 15;
   localparam int PARAM_MAX = 8;

   // Command parser mirror and store of pending command items
   class cmd_scoreboard;
      mode_type    mode;
      logic [7:0]  tok[TOK_MAX];
      int          tlen;
      logic [7:0]  prev;
      logic [7:0]  name[TOK_MAX];
      int          pcount;
      logic [1:0]  pkind[PARAM_MAX];
      logic [31:0] pval[PARAM_MAX];
      cmd_item_type pending_items[$];
      int          errors;
      int          checked;
      int          headers;
      int          err_cmds;

      function new();
         mode = MODE_WAIT;
         tlen = 0;
         prev = CH_SPACE;
         pcount = 0;
         errors = 0;
         checked = 0;
         headers = 0;
         err_cmds = 0;
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         errors++;
      endtask

      function logic [7:0] tok_at(int i);
         return (i < tlen) ? tok[i] : 8'h00;
      endfunction

      function bit delim(logic [7:0] c);
         return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == "_" || c == ",";
      endfunction

      function int digit_value(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "z") return c - "a" + 10;
         if (c >= "A" && c <= "Z") return c - "A" + 10;
         return 99;
      endfunction

      function logic [31:0] clamp32(longint unsigned mag, bit neg);
         if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'h0 - mag[31:0];
         return (mag >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      endfunction

      // leading white space, then optional sign
      function int past_sign(int p, output bit neg);
         neg = 0;
         while (p < tlen && (tok_at(p) == " " || (tok_at(p) >= 9 && tok_at(p) <= 13))) p++;
         if (tok_at(p) == "+" || tok_at(p) == "-") begin
            neg = tok_at(p) == "-";
            p++;
         end
         return p;
      endfunction

      function logic [31:0] int_value(int start, int base);
         bit neg;
         longint unsigned mag;
         int p;
         mag = 0;
         p = past_sign(start, neg);
         if (base == 16 && tok_at(p) == "0" && (tok_at(p+1) == "x" || tok_at(p+1) == "X")
             && digit_value(tok_at(p+2)) < 16)
            p += 2;
         while (p < tlen && digit_value(tok_at(p)) < base) begin
            mag = mag * base + digit_value(tok_at(p));
            if (mag > 64'hFFFF_FFFF) mag = 64'h1_0000_0000;
            p++;
         end
         return clamp32(mag, neg);
      endfunction

      // decimal Q16.16, truncated
      function logic [31:0] fixed_value();
         bit neg;
         longint unsigned ip, frac, den;
         int p;
         ip = 0; frac = 0; den = 1;
         p = past_sign(0, neg);
         while (p < tlen && digit_value(tok_at(p)) < 10) begin
            ip = ip * 10 + digit_value(tok_at(p));
            if (ip > 64'h10000) ip = 64'h10000;
            p++;
         end
         if (tok_at(p) == ".") begin
            p++;
            while (p < tlen && digit_value(tok_at(p)) < 10) begin
               frac = frac * 10 + digit_value(tok_at(p));
               den = den * 10;
               p++;
            end
         end
         return clamp32(ip * 65536 + (frac * 65536) / den, neg);
      endfunction

      function void decode_param();
         int slot;
         logic [7:0] t0;
         logic [7:0] b;
         int base;
         bit dot;
         slot = (pcount < PARAM_MAX) ? pcount : PARAM_MAX - 1;
         t0 = tok_at(0);
         dot = 0;
         if (tlen == 1 && ((t0 >= "A" && t0 <= "Z") || (t0 >= "a" && t0 <= "z"))) begin
            pkind[slot] = KIND_CHAR;
            pval[slot] = {24'h0, t0};
            return;
         end
         if (t0 == CH_HASH) begin
            b = tok_at(1);
            base = 16;
            if (b == "O" || b == "o") base = 8;
            else if (b == "B" || b == "b") base = 2;
            pkind[slot] = KIND_INT;
            pval[slot] = int_value(2, base);
            return;
         end
         for (int k = 0; k < tlen; k++) if (tok_at(k) == CH_DOT) dot = 1;
         pkind[slot] = dot ? KIND_FIX : KIND_INT;
         pval[slot] = dot ? fixed_value() : int_value(0, 10);
      endfunction

      function void queue_command(logic [1:0] code, int count);
         cmd_item_type it;
         if (count > PARAM_MAX) count = PARAM_MAX;
         it.kind = KIND_HEAD;
         for (int k = 0; k < 8; k++) it.name_lo[8*k +: 8] = name[k];
         for (int k = 8; k < TOK_MAX; k++) it.name_hi[8*(k-8) +: 8] = name[k];
         it.value = 0;
         it.total = 4'(count);
         it.code = code;
         it.last = count == 0;
         pending_items.push_back(it);
         headers++;
         if (code != ERR_NONE) err_cmds++;
         for (int k = 0; k < count; k++) begin
            it.kind = pkind[k];
            it.name_lo = 0;
            it.name_hi = 0;
            it.value = pval[k];
            it.total = 0;
            it.code = ERR_NONE;
            it.last = k + 1 == count;
            pending_items.push_back(it);
         end
         mode = MODE_WAIT;
      endfunction

      function void queue_error(logic [1:0] code, int count);
         for (int k = 0; k < TOK_MAX; k++) name[k] = CH_NUL;
         name[0] = CH_E;
         name[1] = CH_R;
         name[2] = CH_R;
         queue_command(code, count);
      endfunction

      // one accepted input byte
      function void note_input(logic [7:0] c);
         if (c == CH_NUL) begin
            tlen = 0; pcount = 0; prev = CH_SPACE;
            return;
         end
         if (c == CH_BANG) begin
            tlen = 0; pcount = 0; prev = CH_SPACE; mode = MODE_WAIT;
            return;
         end
         if (c == CH_COLON) begin
            mode = MODE_NAME; tlen = 0;
            return;
         end
         case (mode)
            MODE_NAME: begin
               if (tlen >= TOK_MAX) begin
                  queue_error(ERR_NAME_LONG, 0);
               end else if (c == CH_SEMI) begin
                  for (int k = tlen; k < TOK_MAX; k++) name[k] = CH_NUL;
                  pcount = 0;
                  queue_command(ERR_NONE, 0);
               end else if (delim(c)) begin
                  for (int k = tlen; k < TOK_MAX; k++) name[k] = CH_NUL;
                  mode = MODE_PARAM; tlen = 0; pcount = 0; prev = c;
               end else begin
                  name[tlen] = c;
                  tlen++;
               end
            end
            MODE_PARAM: begin
               if (delim(c) || c == CH_SEMI) begin
                  if (delim(prev)) return;
                  decode_param();
                  tlen = 0;
                  if (pcount < PARAM_MAX) pcount++;
                  if (c == CH_SEMI) begin
                     queue_command(ERR_NONE, pcount);
                     return;
                  end
                  if (pcount >= PARAM_MAX) begin
                     queue_error(ERR_TOO_MANY, pcount);
                     return;
                  end
               end else begin
                  if (tlen >= TOK_MAX) begin
                     queue_error(ERR_PARM_LONG, pcount);
                     return;
                  end
                  tok[tlen] = c;
                  tlen++;
               end
               prev = c;
            end
            default: begin
               mode = MODE_WAIT; tlen = 0; pcount = 0;
            end
         endcase
      endfunction

      task check_result(cmd_item_type got);
         cmd_item_type want;
         if (pending_items.size() == 0) begin
            report($sformatf("unexpected item kind %0d value %h", got.kind, got.value));
            return;
         end
         want = pending_items.pop_front();
         checked++;
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.name_lo !== want.name_lo)
            report($sformatf("name_low %h, want %h", got.name_lo, want.name_lo));
         if (got.name_hi !== want.name_hi)
            report($sformatf("name_high %h, want %h", got.name_hi, want.name_hi));
         if (got.value !== want.value)
            report($sformatf("param_value %h, want %h", got.value, want.value));
         if (got.total !== want.total)
            report($sformatf("param_total %0d, want %0d", got.total, want.total));
         if (got.code !== want.code)
            report($sformatf("error_code %0d, want %0d", got.code, want.code));
         if (got.last !== want.last)
            report($sformatf("last_item %0d, want %0d", got.last, want.last));
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   bit   calm = 0;
   int   hold_left = 0;
   int   bytes_sent = 0;
   cmd_scoreboard sb;

   tct_req_if req_chan();
   tct_rsp_if rsp_chan();

   text_command_tokenizer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d items outstanding", sb.pending_items.size());
      $display("FAILURE");
      $finish;
   end

   // response side: random stalls, plus long hold-offs on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(99) >= 11);
         end
      end
   end

   // sample both channels at the edge
   always @(posedge clock) begin
      cmd_item_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_input(req_chan.char_in);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind = rsp_chan.item_kind;
            got.name_lo = rsp_chan.name_low;
            got.name_hi = rsp_chan.name_high;
            got.value = rsp_chan.param_value;
            got.total = rsp_chan.param_total;
            got.code = rsp_chan.error_code;
            got.last = rsp_chan.last_item;
            sb.check_result(got);
         end
      end
   end

   task send_byte(logic [7:0] b);
      req_chan.valid <= 1'b1;
      req_chan.char_in <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      if (!calm && $urandom_range(99) < 11) begin
         req_chan.valid <= 1'b0;
         req_chan.char_in <= 8'($urandom_range(255));
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function string pick_from(string set, int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, set.substr(0, 0)};
      for (int i = 0; i < n; i++) s[i] = set[$urandom_range(set.len() - 1)];
      return s;
   endfunction

   function string rand_sign();
      case ($urandom_range(3))
         0: return "-";
         1: return "+";
         default: return "";
      endcase
   endfunction

   // one random parameter token, mostly well formed
   function string rand_param();
      string s;
      case ($urandom_range(5))
         0: s = pick_from("abcxyzABCXYZ", 1);
         1: begin
            s = {"#", pick_from("HhOoBbqX", 1)};
            case (s[1])
               "O", "o": s = {s, rand_sign(), pick_from("01234567", $urandom_range(1, 11))};
               "B", "b": s = {s, rand_sign(), pick_from("01", $urandom_range(1, 12))};
               default: begin
                  if ($urandom_range(3) == 0) s = {s, "0x"};
                  s = {s, pick_from("0123456789abcdefABCDEF", $urandom_range(0, 9))};
               end
            endcase
         end
         2: s = {rand_sign(), pick_from("0123456789", $urandom_range(1, 12))};
         3: s = {rand_sign(), pick_from("0123456789", $urandom_range(0, 6)), ".",
                 pick_from("0123456789", $urandom_range(0, 7))};
         4: s = {rand_sign(), pick_from("gkqwGK+-.", $urandom_range(2, 5))};
         default: s = pick_from("0123456789", $urandom_range(1, 5));
      endcase
      if ($urandom_range(19) == 0) s = {s, pick_from("0123456789", $urandom_range(6, 10))};
      return s;
   endfunction

   task send_random_command();
      string s;
      string dl;
      int np;
      s = {":", pick_from("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789",
                          ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 15))};
      np = $urandom_range(0, 9);
      for (int i = 0; i < np; i++) begin
         dl = pick_from(" ,_\t\r\n", 1);
         if ($urandom_range(7) == 0) dl = {dl, pick_from(" ,_", 1)};
         s = {s, dl, rand_param()};
      end
      if ($urandom_range(15) == 0) s = {s, "!"};
      if (np == 8 && $urandom_range(1) == 0) s = {s, ","};
      else s = {s, ";"};
      send_text(s);
      // occasional line noise, any byte value
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      sb = new();
      req_chan.valid = 1'b0;
      req_chan.char_in = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed commands: every kind, base, saturation and error path
      send_text(":A;");
      send_text(":GO x,Z;");
      send_text(":HEX #hFF,#o17,#b101,#q7f,#H0x1F,#B-11;");
      send_text(":NUM 0,-2147483648,99999999999,-99999999999,+42;");
      send_text(":FX 3.25,-1.5,70000.5,.5,-0.;");
      send_text(":BH #,#x,abc;");
      send_text(":S 1,;2;");
      send_text(":ABCDEFGHIJKLMNOPQ;");
      send_text(":P 1,2,3,4,5,6,7,8,");
      send_text(":Q 1234567890123456;");
      send_text(":R 1,\v7;");
      send_text(":Z 5!:Y 1:W 2;");
      send_text(":T 4");
      send_byte(CH_NUL);
      send_text("5;");
      send_byte(8'hFF);

      // receiver holds off while commands keep flowing in
      hold_left = 400;
      while (bytes_sent < 430) begin
         calm = bytes_sent > 250 && bytes_sent < 330;
         send_random_command();
      end
      calm = 0;
      req_chan.valid <= 1'b0;

      while (sb.pending_items.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("sent %0d bytes, %0d commands, %0d of them error commands",
               bytes_sent, sb.headers, sb.err_cmds);
      $display("checked %0d result items across all parameter kinds", sb.checked);
      if (sb.errors == 0 && sb.pending_items.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
